// ===== sv/pojtt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pojtt_pkg;

    // Table geometry
    localparam int JOBS      = 16;
    localparam int TIME_BITS = 40;
    localparam int IDX_W     = (JOBS > 1) ? $clog2(JOBS) : 1;
    localparam int CNT_W     = $clog2(JOBS + 1);

    typedef logic [TIME_BITS-1:0] t_time;
    localparam t_time TIME_MAX = '1;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_ARM    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RK_FIRED     = 2'd0,
        RK_DONE      = 2'd1,
        RK_FULL      = 2'd2,
        RK_NOT_FOUND = 2'd3
    } t_rkind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_PROC,
        ST_EMIT_RD,
        ST_EMIT,
        ST_DONE
    } t_state;

    // Input beat
    typedef struct packed {
        logic [1:0]  opcode;
        logic [39:0] current_time;
        logic [31:0] job_tag;
        logic        job_kind;
        logic [31:0] interval;
        logic [39:0] at_time;
        logic        delete_after_fire;
    } t_in_item;

    // Output beat
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] fired_tag;
        logic [4:0]  entry_count;
        logic        table_changed;
        logic        last_result;
    } t_out_item;

    // One job record as held in the table memory
    typedef struct packed {
        logic [31:0] tag;
        logic        en;
        logic        one;
        logic        del;
        logic [31:0] period;
        t_time       at;
        t_time       due;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Result of updating one entry during a scan
    typedef struct packed {
        logic   fire;
        logic   keep;
        logic   changed;
        t_entry entry;
    } t_upd;

    // now + period, saturating at the largest time
    function automatic t_time sat_add(input t_time a, input logic [31:0] b);
        logic [TIME_BITS:0] s;
        begin
            s = {1'b0, a} + (TIME_BITS + 1)'(b);
            sat_add = s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/pojtt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pojtt_in_if;
    logic               valid;
    logic               ready;
    pojtt_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pojtt_out_if;
    logic                 valid;
    logic                 ready;
    pojtt_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/periodic_oneshot_job_timer_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Timed-job table of up to 16 entries kept in insertion order, one command per input beat.
// Add writes the new record straight into the table memory.
// Tick, remove and arm walk the table through its registered-read memory, a read per held
// job and a write-back per kept one, compacting the table as entries are dropped;
// tags of fired jobs are queued in a second memory and sent one by one after the walk,
// so every beat of a step carries the final entry count. One command is in flight at a
// time; the last beat of a step may still wait in the output register while the next
// command is taken.
module periodic_oneshot_job_timer_table (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pojtt_in_if.sink    i_in,
    pojtt_out_if.source o_out
);

    localparam int IW = pojtt_pkg::IDX_W;
    localparam int CW = pojtt_pkg::CNT_W;

    pojtt_pkg::t_state    r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_rd, n_rd;
    logic [CW-1:0]        r_wr, n_wr;
    logic [CW-1:0]        r_fcnt, n_fcnt;
    logic [CW-1:0]        r_emit, n_emit;
    logic                 r_chg, n_chg;
    pojtt_pkg::t_rkind    r_kind, n_kind;
    pojtt_pkg::t_op       r_op, n_op;
    pojtt_pkg::t_time     r_now, n_now;
    logic [31:0]          r_key, n_key;
    logic                 r_out_valid;
    pojtt_pkg::t_out_item r_out, n_out;
    logic                 out_load;

    logic                  ent_we;
    logic [IW-1:0]         ent_waddr;
    pojtt_pkg::t_entry     ent_wdata;
    logic [pojtt_pkg::ENTRY_W-1:0] ent_rdata;
    logic                  fire_we;
    logic [31:0]           fire_rdata;
    pojtt_pkg::t_upd       upd;

    logic accept, slot_free;
    pojtt_pkg::t_time in_now, in_at;

    assign i_in.ready  = (r_state == pojtt_pkg::ST_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign slot_free   = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;
    assign in_now = pojtt_pkg::t_time'(i_in.payload.current_time);
    assign in_at  = pojtt_pkg::t_time'(i_in.payload.at_time);

    // Job records
    pojtt_ram #(.WIDTH(pojtt_pkg::ENTRY_W), .DEPTH(pojtt_pkg::JOBS)) u_tab (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (r_rd[IW-1:0]),
        .o_rdata (ent_rdata)
    );

    // Queue of fired tags for the current tick
    pojtt_ram #(.WIDTH(32), .DEPTH(pojtt_pkg::JOBS)) u_fired (
        .i_clk   (i_clk),
        .i_we    (fire_we),
        .i_waddr (r_fcnt[IW-1:0]),
        .i_wdata (upd.entry.tag),
        .i_raddr (r_emit[IW-1:0]),
        .o_rdata (fire_rdata)
    );

    pojtt_upd u_upd (
        .i_op    (r_op),
        .i_now   (r_now),
        .i_key   (r_key),
        .i_found (r_chg),
        .i_entry (pojtt_pkg::t_entry'(ent_rdata)),
        .o_upd   (upd)
    );

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_fcnt    = r_fcnt;
        n_emit    = r_emit;
        n_chg     = r_chg;
        n_kind    = r_kind;
        n_op      = r_op;
        n_now     = r_now;
        n_key     = r_key;
        n_out     = '0;
        out_load  = 1'b0;
        ent_we    = 1'b0;
        ent_waddr = r_wr[IW-1:0];
        ent_wdata = upd.entry;
        fire_we   = 1'b0;
        case (r_state)
            pojtt_pkg::ST_IDLE: begin
                if (accept) begin
                    n_op   = pojtt_pkg::t_op'(i_in.payload.opcode);
                    n_now  = in_now;
                    n_key  = i_in.payload.job_tag;
                    n_chg  = 1'b0;
                    n_rd   = '0;
                    n_wr   = '0;
                    n_fcnt = '0;
                    n_kind = pojtt_pkg::RK_DONE;
                    n_state = pojtt_pkg::ST_DONE;
                    if (n_op == pojtt_pkg::OP_ADD) begin
                        if (r_count >= CW'(pojtt_pkg::JOBS)) begin
                            n_kind = pojtt_pkg::RK_FULL;
                        end else begin
                            ent_we           = 1'b1;
                            ent_waddr        = r_count[IW-1:0];
                            ent_wdata.tag    = i_in.payload.job_tag;
                            ent_wdata.en     = 1'b1;
                            ent_wdata.one    = i_in.payload.job_kind;
                            ent_wdata.del    = i_in.payload.delete_after_fire;
                            ent_wdata.period = i_in.payload.interval;
                            ent_wdata.at     = in_at;
                            if (!i_in.payload.job_kind) begin
                                ent_wdata.due = pojtt_pkg::sat_add(in_now, i_in.payload.interval);
                            end else if (in_at > in_now) begin
                                ent_wdata.due = in_at;
                            end else begin
                                ent_wdata.due = '0;
                                ent_wdata.en  = 1'b0;
                            end
                            n_count = r_count + 1'b1;
                            n_chg   = 1'b1;
                        end
                    end else if (r_count == '0) begin
                        if (n_op == pojtt_pkg::OP_REMOVE) begin
                            n_kind = pojtt_pkg::RK_NOT_FOUND;
                        end
                    end else begin
                        n_state = pojtt_pkg::ST_RD;
                    end
                end
            end
            pojtt_pkg::ST_RD: begin
                n_state = pojtt_pkg::ST_PROC;
            end
            pojtt_pkg::ST_PROC: begin
                if (upd.keep) begin
                    ent_we = 1'b1;
                    n_wr   = r_wr + 1'b1;
                end
                if (upd.fire) begin
                    fire_we = 1'b1;
                    n_fcnt  = r_fcnt + 1'b1;
                end
                n_chg = r_chg | upd.changed;
                n_rd  = r_rd + 1'b1;
                if (n_rd == r_count) begin
                    n_count = n_wr;
                    n_emit  = '0;
                    if (r_op == pojtt_pkg::OP_REMOVE && !n_chg) begin
                        n_kind = pojtt_pkg::RK_NOT_FOUND;
                    end
                    n_state = (n_fcnt != '0) ? pojtt_pkg::ST_EMIT_RD : pojtt_pkg::ST_DONE;
                end else begin
                    n_state = pojtt_pkg::ST_RD;
                end
            end
            pojtt_pkg::ST_EMIT_RD: begin
                n_state = pojtt_pkg::ST_EMIT;
            end
            pojtt_pkg::ST_EMIT: begin
                if (slot_free) begin
                    out_load          = 1'b1;
                    n_out.result_kind = pojtt_pkg::RK_FIRED;
                    n_out.fired_tag   = fire_rdata;
                    n_out.entry_count = 5'(r_count);
                    n_emit = r_emit + 1'b1;
                    n_state = (n_emit == r_fcnt) ? pojtt_pkg::ST_DONE : pojtt_pkg::ST_EMIT_RD;
                end
            end
            pojtt_pkg::ST_DONE: begin
                if (slot_free) begin
                    out_load            = 1'b1;
                    n_out.result_kind   = r_kind;
                    n_out.entry_count   = 5'(r_count);
                    n_out.table_changed = (r_kind == pojtt_pkg::RK_DONE) && r_chg;
                    n_out.last_result   = 1'b1;
                    n_state = pojtt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pojtt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pojtt_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and output beat
    always_ff @(posedge i_clk) begin
        r_rd   <= n_rd;
        r_wr   <= n_wr;
        r_fcnt <= n_fcnt;
        r_emit <= n_emit;
        r_chg  <= n_chg;
        r_kind <= n_kind;
        r_op   <= n_op;
        r_now  <= n_now;
        r_key  <= n_key;
        if (out_load) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pojtt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pojtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/pojtt_upd.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pojtt_upd (
    input  wire pojtt_pkg::t_op    i_op,
    input  wire pojtt_pkg::t_time  i_now,
    input  wire logic [31:0]       i_key,
    input  wire logic              i_found,
    input  wire pojtt_pkg::t_entry i_entry,
    output pojtt_pkg::t_upd        o_upd
);

    // Per-entry modify step of the scan
    always_comb begin
        o_upd         = '0;
        o_upd.keep    = 1'b1;
        o_upd.entry   = i_entry;
        case (i_op)
            pojtt_pkg::OP_TICK: begin
                if (i_entry.en && i_entry.due != '0 && i_entry.due <= i_now) begin
                    o_upd.fire    = 1'b1;
                    o_upd.changed = 1'b1;
                    if (i_entry.one) begin
                        if (i_entry.del) begin
                            o_upd.keep = 1'b0;
                        end else begin
                            o_upd.entry.en  = 1'b0;
                            o_upd.entry.due = '0;
                        end
                    end else begin
                        o_upd.entry.due = pojtt_pkg::sat_add(i_now, i_entry.period);
                    end
                end
            end
            pojtt_pkg::OP_REMOVE: begin
                // first match only
                if (!i_found && i_entry.tag == i_key) begin
                    o_upd.keep    = 1'b0;
                    o_upd.changed = 1'b1;
                end
            end
            pojtt_pkg::OP_ARM: begin
                if (i_entry.en && i_entry.due == '0) begin
                    if (!i_entry.one) begin
                        o_upd.entry.due = pojtt_pkg::sat_add(i_now, i_entry.period);
                        o_upd.changed   = 1'b1;
                    end else if (i_entry.at > i_now) begin
                        o_upd.entry.due = i_entry.at;
                        o_upd.changed   = 1'b1;
                    end
                end
            end
            default: begin
                o_upd.keep = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/pojtt_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pojtt_chk (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 i_in_ready,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire pojtt_pkg::t_out_item i_out
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("output beat changed while stalled");

    // Count never exceeds the table size
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out.entry_count <= 5'(pojtt_pkg::JOBS))
        else $error("entry count out of range");

    // Fired beats are never last; other beats are last and carry no tag
    a_fired_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out.result_kind == pojtt_pkg::RK_FIRED)
            ? (!i_out.last_result && !i_out.table_changed)
            : (i_out.last_result && i_out.fired_tag == '0)))
        else $error("malformed result beat");

    // One command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken while busy");

endmodule

bind periodic_oneshot_job_timer_table pojtt_chk u_pojtt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out       (o_out.payload)
);

`default_nettype wire

// ===== verif/tb_pojtt_checker.sv =====
`timescale 1ns / 1ps

module tb_pojtt_checker
    import pojtt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    pojtt_in_if    i_in,
    pojtt_out_if   i_out,
    output int     o_errors,
    output int     o_pending,
    output int     o_beats_out,
    output int     o_fired_seen
);

    // Shadow copy of the job table
    logic [31:0] sh_tag    [JOBS];
    logic        sh_en     [JOBS];
    logic        sh_one    [JOBS];
    logic        sh_del    [JOBS];
    logic [31:0] sh_period [JOBS];
    t_time       sh_at     [JOBS];
    t_time       sh_due    [JOBS];
    int          sh_count;

    t_out_item   result_q[$];

    function automatic t_time time_sat_add(t_time a, logic [31:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {{(TIME_BITS+1-32){1'b0}}, b};
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    task automatic drop_job(int idx);
        for (int j = idx; j + 1 < sh_count; j++) begin
            sh_tag[j]    = sh_tag[j+1];
            sh_en[j]     = sh_en[j+1];
            sh_one[j]    = sh_one[j+1];
            sh_del[j]    = sh_del[j+1];
            sh_period[j] = sh_period[j+1];
            sh_at[j]     = sh_at[j+1];
            sh_due[j]    = sh_due[j+1];
        end
        sh_count--;
    endtask

    // Apply one command to the shadow table and queue its result beats
    task automatic run_command(t_in_item c);
        t_out_item   outs[$];
        t_out_item   r;
        logic        chg;
        int          i;
        t_time       now;
        t_rkind      fin;
        now = c.current_time;
        chg = 1'b0;
        fin = RK_DONE;
        case (t_op'(c.opcode))
            OP_TICK: begin
                i = 0;
                while (i < sh_count) begin
                    if (!sh_en[i] || sh_due[i] == '0 || sh_due[i] > now) begin
                        i++;
                        continue;
                    end
                    r = '0;
                    r.result_kind = RK_FIRED;
                    r.fired_tag = sh_tag[i];
                    outs.push_back(r);
                    chg = 1'b1;
                    if (sh_one[i]) begin
                        if (sh_del[i]) begin
                            drop_job(i);
                            continue;
                        end
                        sh_en[i] = 1'b0;
                        sh_due[i] = '0;
                    end else begin
                        sh_due[i] = time_sat_add(now, sh_period[i]);
                    end
                    i++;
                end
            end
            OP_ADD: begin
                if (sh_count >= JOBS) begin
                    fin = RK_FULL;
                end else begin
                    i = sh_count;
                    sh_tag[i] = c.job_tag;
                    sh_en[i] = 1'b1;
                    sh_one[i] = c.job_kind;
                    sh_del[i] = c.delete_after_fire;
                    sh_period[i] = c.interval;
                    sh_at[i] = c.at_time;
                    if (!c.job_kind) sh_due[i] = time_sat_add(now, c.interval);
                    else if (c.at_time > now) sh_due[i] = c.at_time;
                    else begin
                        sh_due[i] = '0;
                        sh_en[i] = 1'b0;
                    end
                    sh_count++;
                    chg = 1'b1;
                end
            end
            OP_REMOVE: begin
                for (i = 0; i < sh_count; i++)
                    if (sh_tag[i] == c.job_tag) break;
                if (i < sh_count) begin
                    drop_job(i);
                    chg = 1'b1;
                end else begin
                    fin = RK_NOT_FOUND;
                end
            end
            default: begin
                for (i = 0; i < sh_count; i++) begin
                    if (!sh_en[i] || sh_due[i] != '0) continue;
                    if (!sh_one[i]) begin
                        sh_due[i] = time_sat_add(now, sh_period[i]);
                        chg = 1'b1;
                    end else if (sh_at[i] > now) begin
                        sh_due[i] = sh_at[i];
                        chg = 1'b1;
                    end
                end
            end
        endcase
        r = '0;
        r.result_kind = fin;
        r.table_changed = chg;
        r.last_result = 1'b1;
        outs.push_back(r);
        foreach (outs[k]) begin
            outs[k].entry_count = 5'(sh_count);
            result_q.push_back(outs[k]);
        end
    endtask

    // Watch both channels
    always @(posedge i_clk) begin
        t_out_item exp_r;
        t_out_item got;
        if (!i_rst_n) begin
            sh_count = 0;
            result_q.delete();
            o_errors <= 0;
            o_beats_out <= 0;
            o_fired_seen <= 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = i_out.payload;
                o_beats_out <= o_beats_out + 1;
                if (got.result_kind == RK_FIRED) o_fired_seen <= o_fired_seen + 1;
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = result_q.pop_front();
                    if (got.result_kind !== exp_r.result_kind ||
                        got.fired_tag !== exp_r.fired_tag ||
                        got.entry_count !== exp_r.entry_count ||
                        got.table_changed !== exp_r.table_changed ||
                        got.last_result !== exp_r.last_result) begin
                        $display("%0t: mismatch expected kind=%0d tag=%h cnt=%0d chg=%0b last=%0b",
                                 $time, exp_r.result_kind, exp_r.fired_tag,
                                 exp_r.entry_count, exp_r.table_changed, exp_r.last_result);
                        $display("%0t:          actual   kind=%0d tag=%h cnt=%0d chg=%0b last=%0b",
                                 $time, got.result_kind, got.fired_tag,
                                 got.entry_count, got.table_changed, got.last_result);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready) run_command(i_in.payload);
        end
        o_pending <= result_q.size();
    end

endmodule

// ===== verif/tb_periodic_oneshot_job_timer_table.sv =====
`timescale 1ns / 1ps

module tb_periodic_oneshot_job_timer_table;
    import pojtt_pkg::*;

    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pojtt_in_if  in_ch();
    pojtt_out_if out_ch();

    int errors, pending, beats_out, fired_seen;
    int idle_pct = 0;     // sender idle odds
    int stall_pct = 0;    // receiver stall odds
    bit long_hold = 0;
    int stall_cycles = 0;
    int quiet_cycles = 0;
    int sent = 0;

    // Shadow of tags and clock for building sensible commands
    logic [31:0] tag_pool[$];
    t_time       clock_now = 40'd100;

    periodic_oneshot_job_timer_table u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    tb_pojtt_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_beats_out (beats_out),
        .o_fired_seen(fired_seen)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
    end

    // Receiver ready, with an optional long hold-off
    always @(posedge i_clk) begin
        if (long_hold) begin
            out_ch.ready <= 1'b0;
            stall_cycles <= stall_cycles + 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || long_hold)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired, %0d results outstanding", pending);
            $display("periodic_oneshot_job_timer_table regression: fail");
            $finish;
        end
    end

    // Drive one beat and wait for its handshake; valid drops only on idle cycles
    task automatic send_beat(t_in_item c);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= c;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    // Take the sender off the bus after its last beat
    task automatic stop_sending();
        in_ch.valid <= 1'b0;
    endtask

    function automatic t_in_item make_cmd(t_op op, t_time now, logic [31:0] tag, logic kind,
                                          logic [31:0] ival, t_time at, logic del);
        t_in_item c;
        c.opcode = op;
        c.current_time = now;
        c.job_tag = tag;
        c.job_kind = kind;
        c.interval = ival;
        c.at_time = at;
        c.delete_after_fire = del;
        return c;
    endfunction

    function automatic logic [39:0] rand40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // Mostly a well-formed timeline with random content, some noise
    task automatic random_cmd();
        t_in_item c;
        int r;
        logic [31:0] tg;
        r = $urandom_range(99);
        clock_now = clock_now + 40'($urandom_range(8));
        c = make_cmd(OP_TICK, clock_now, $urandom, 1'($urandom), $urandom, rand40(),
                     1'($urandom));
        if (r < 5) begin
            c = make_cmd(t_op'($urandom_range(3)), rand40(), $urandom, 1'($urandom), $urandom,
                         rand40(), 1'($urandom));
        end else if (r < 40) begin
            c.opcode = OP_ADD;
            tg = (tag_pool.size() > 0 && $urandom_range(9) == 0) ?
                 tag_pool[$urandom_range(tag_pool.size()-1)] : $urandom;
            c.job_tag = tg;
            c.interval = ($urandom_range(9) == 0) ? $urandom : $urandom_range(12);
            c.at_time = ($urandom_range(9) == 0) ? rand40() :
                        clock_now + 40'($urandom_range(20)) - 40'd4;
            if (tag_pool.size() < 40) tag_pool.push_back(tg);
        end else if (r < 55) begin
            c.opcode = OP_REMOVE;
            if (tag_pool.size() > 0 && $urandom_range(3) != 0)
                c.job_tag = tag_pool[$urandom_range(tag_pool.size()-1)];
        end else if (r < 65) begin
            c.opcode = OP_ARM;
        end
        send_beat(c);
    endtask

    task automatic drain();
        stop_sending();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        t_time top;
        top = '1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extremes, all opcodes, full table, saturation
        send_beat(make_cmd(OP_TICK, '0, '0, 1'b0, '0, '0, 1'b0));
        send_beat(make_cmd(OP_REMOVE, 40'd5, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0));
        send_beat(make_cmd(OP_ARM, top, '0, 1'b0, '0, '0, 1'b0));
        send_beat(make_cmd(OP_ADD, top - 40'd3, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, top, 1'b1));
        send_beat(make_cmd(OP_ADD, 40'd10, 32'd0, 1'b1, '0, 40'd10, 1'b0));
        send_beat(make_cmd(OP_ADD, 40'd10, 32'd7, 1'b1, '0, 40'd12, 1'b1));
        send_beat(make_cmd(OP_ADD, 40'd10, 32'd8, 1'b1, '0, 40'd12, 1'b0));
        send_beat(make_cmd(OP_ADD, 40'd10, 32'd7, 1'b0, 32'd0, '0, 1'b0));
        send_beat(make_cmd(OP_ADD, 40'd10, 32'hA5A5_5A5A, 1'b0, 32'd3, top, 1'b1));
        send_beat(make_cmd(OP_TICK, 40'd12, '0, 1'b0, '0, '0, 1'b0));
        send_beat(make_cmd(OP_ARM, 40'd11, '0, 1'b0, '0, '0, 1'b0));
        send_beat(make_cmd(OP_TICK, top, '0, 1'b0, '0, '0, 1'b0));
        send_beat(make_cmd(OP_REMOVE, 40'd0, 32'd7, 1'b0, '0, '0, 1'b0));
        for (int k = 0; k < 12; k++)
            send_beat(make_cmd(OP_ADD, 40'd20, 32'h100 + 32'(k), k[0], 32'(k), 40'd25, k[1]));
        send_beat(make_cmd(OP_ADD, 40'd20, 32'h5555_AAAA, 1'b0, '0, '0, 1'b0));
        send_beat(make_cmd(OP_TICK, 40'd30, '0, 1'b0, '0, '0, 1'b0));
        drain();
        // Clear the table before the random part
        for (int k = 0; k < 17; k++)
            send_beat(make_cmd(OP_REMOVE, '0, 32'h100 + 32'(k), 1'b0, '0, '0, 1'b0));
        send_beat(make_cmd(OP_REMOVE, '0, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0));
        send_beat(make_cmd(OP_REMOVE, '0, 32'hA5A5_5A5A, 1'b0, '0, '0, 1'b0));
        send_beat(make_cmd(OP_REMOVE, '0, 32'h5555_AAAA, 1'b0, '0, '0, 1'b0));
        send_beat(make_cmd(OP_REMOVE, '0, 32'd8, 1'b0, '0, '0, 1'b0));
        send_beat(make_cmd(OP_REMOVE, '0, 32'd7, 1'b0, '0, '0, 1'b0));
        send_beat(make_cmd(OP_REMOVE, '0, 32'd0, 1'b0, '0, '0, 1'b0));

        // Random phases with different idle mixes
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 20 : 59) : 0;
            stall_pct = (ph == 2) ? 59 : ((ph == 3) ? 20 : 0);
            for (int k = 0; k < 85; k++) random_cmd();
            drain();
        end

        // Long receiver hold-off while commands keep coming
        fork
            begin
                long_hold = 1'b1;
                while (stall_cycles < 300) @(posedge i_clk);
                long_hold = 1'b0;
            end
            begin
                idle_pct = 0;
                for (int k = 0; k < 30; k++) random_cmd();
                stop_sending();
            end
        join
        drain();

        $display("ran %0d commands, checked %0d result beats of which %0d fired jobs",
                 sent, beats_out, fired_seen);
        $display("covered add/remove/tick/arm, full table, saturation, idle and stall mixes");
        if (errors == 0 && pending == 0) begin
            $display("periodic_oneshot_job_timer_table regression: pass");
        end else begin
            $display("periodic_oneshot_job_timer_table regression: fail");
        end
        $finish;
    end

endmodule
